FILE: hw/rtl/hsvrgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared widths, constants and sector codes for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int HUE_W   = 13;
    localparam int CH_W    = 8;
    localparam int FRAC_W  = 16;   // chroma / offset format, 65025 = 1.0
    localparam int WGT_W   = 10;   // ramp weight 0..960
    localparam int PROD_W  = FRAC_W + WGT_W;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    localparam logic [CH_W-1:0] UNIT8 = 8'hFF;

    // 60 degree sector boundaries, hue in 1/16 degree
    localparam logic [HUE_W-1:0] HUE_60  = 13'd960;
    localparam logic [HUE_W-1:0] HUE_120 = 13'd1920;
    localparam logic [HUE_W-1:0] HUE_180 = 13'd2880;
    localparam logic [HUE_W-1:0] HUE_240 = 13'd3840;
    localparam logic [HUE_W-1:0] HUE_300 = 13'd4800;
    localparam logic [HUE_W-1:0] HUE_360 = 13'd5760;
    localparam logic [HUE_W-1:0] HUE_480 = 13'd7680;

    // floor(n/15) = (n * RECIP15) >> 24, exact for n < 2^20
    localparam int                RECIP15_W = 21;
    localparam logic [RECIP15_W-1:0] RECIP15 = 21'd1118482;
    localparam int                RECIP_SHIFT = 24;

    // floor(n/255) = (n * RECIP255) >> 24, exact for n <= 65025
    localparam int                 RECIP255_W = 17;
    localparam logic [RECIP255_W-1:0] RECIP255 = 17'd65794;

    // sector codes, one per 60 degrees
    localparam logic [2:0] SEC_RED_YEL   = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN   = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN   = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU   = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG   = 3'd4;
    localparam logic [2:0] SEC_MAG_RED   = 3'd5;

endpackage

FILE: hw/rtl/hsv_to_rgb_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel
// Fixed-point HSV to 8-bit RGB pixel converter, five-stage pipeline.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload (tdata, low bit first)                      Width
//  s side    in   hue[12:0], saturation[20:13], brightness[28:21]     32
//  m side    out  red[7:0], green[15:8], blue[23:16]                  24
//
// An accepted pixel is registered in every stage in turn, and o_m_tvalid comes
// from the last; one pixel per clock is sustained while i_m_tready stays high.
// Each stage holds a valid bit; a stage loads whenever it is empty or the
// stage after it is moving, so bubbles collapse under backpressure.
// i_m_tready low stalls only the full stages at the tail; nothing is lost or
// repeated. Synchronous active-low reset clears the valid bits only.
//
// Stage 1: chroma = V*S, offset m = V*(255-S), sector and ramp weight from hue.
// Stage 2: chroma * weight (16x10).
// Stage 3: divide by 960 as >>6 then reciprocal multiply for /15.
// Stage 4: sector table places chroma and x, offset added per channel.
// Stage 5: three reciprocal divides by 255 into the output register.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // hue[12:0], saturation[20:13], brightness[28:21], zero pad [31:29]
    input  logic [hsvrgb_pkg::S_TDATA_W-1:0]    i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [hsvrgb_pkg::M_TDATA_W-1:0]    o_m_tdata
);

    localparam int NSTG   = 5;
    localparam int FW     = hsvrgb_pkg::FRAC_W;
    localparam int CW     = hsvrgb_pkg::CH_W;
    localparam int HW     = hsvrgb_pkg::HUE_W;
    localparam int WW     = hsvrgb_pkg::WGT_W;
    localparam int PW     = hsvrgb_pkg::PROD_W;
    localparam int QIN_W  = PW - 6;                          // prod >> 6
    localparam int QMUL_W = QIN_W + hsvrgb_pkg::RECIP15_W;

    // ------------------------------------------------------------------
    // Stage flow control
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;
    logic [NSTG-1:0] w_prev_vld;

    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_prev_vld = {r_vld[NSTG-2:0], i_s_tvalid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_prev_vld[k];
                end
            end
        end
    end

    assign o_s_tready = w_rdy[0];
    assign o_m_tvalid = r_vld[NSTG-1];

    // ------------------------------------------------------------------
    // Stage 1: products and hue decode
    // ------------------------------------------------------------------
    logic [HW-1:0] w_hue;
    logic [CW-1:0] w_sat;
    logic [CW-1:0] w_val;
    logic [HW-1:0] w_phase;    // hue mod 1920
    logic [2:0]    n_sector;
    logic [WW-1:0] n_wgt;      // 960 - |phase - 960|

    assign w_hue = i_s_tdata[HW-1:0];
    assign w_sat = i_s_tdata[HW +: CW];
    assign w_val = i_s_tdata[HW+CW +: CW];

    always_comb begin
        if (w_hue >= hsvrgb_pkg::HUE_300)      n_sector = hsvrgb_pkg::SEC_MAG_RED;
        else if (w_hue >= hsvrgb_pkg::HUE_240) n_sector = hsvrgb_pkg::SEC_BLU_MAG;
        else if (w_hue >= hsvrgb_pkg::HUE_180) n_sector = hsvrgb_pkg::SEC_CYN_BLU;
        else if (w_hue >= hsvrgb_pkg::HUE_120) n_sector = hsvrgb_pkg::SEC_GRN_CYN;
        else if (w_hue >= hsvrgb_pkg::HUE_60)  n_sector = hsvrgb_pkg::SEC_YEL_GRN;
        else                                   n_sector = hsvrgb_pkg::SEC_RED_YEL;

        // hue can reach 8191, so up to four 120 degree periods come off
        if (w_hue >= hsvrgb_pkg::HUE_480)      w_phase = w_hue - hsvrgb_pkg::HUE_480;
        else if (w_hue >= hsvrgb_pkg::HUE_360) w_phase = w_hue - hsvrgb_pkg::HUE_360;
        else if (w_hue >= hsvrgb_pkg::HUE_240) w_phase = w_hue - hsvrgb_pkg::HUE_240;
        else if (w_hue >= hsvrgb_pkg::HUE_120) w_phase = w_hue - hsvrgb_pkg::HUE_120;
        else                                   w_phase = w_hue;

        if (w_phase < hsvrgb_pkg::HUE_60) begin
            n_wgt = w_phase[WW-1:0];
        end else begin
            n_wgt = WW'(hsvrgb_pkg::HUE_120 - w_phase);
        end
    end

    logic [FW-1:0] r1_chroma;
    logic [FW-1:0] r1_ofs;
    logic [WW-1:0] r1_wgt;
    logic [2:0]    r1_sector;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_s_tvalid) begin
            r1_chroma <= FW'(w_val) * FW'(w_sat);
            r1_ofs    <= FW'(w_val) * FW'(hsvrgb_pkg::UNIT8 - w_sat);
            r1_wgt    <= n_wgt;
            r1_sector <= n_sector;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: chroma * weight
    // ------------------------------------------------------------------
    logic [PW-1:0] r2_prod;
    logic [FW-1:0] r2_chroma;
    logic [FW-1:0] r2_ofs;
    logic [2:0]    r2_sector;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1] && r_vld[0]) begin
            r2_prod   <= PW'(r1_chroma) * PW'(r1_wgt);
            r2_chroma <= r1_chroma;
            r2_ofs    <= r1_ofs;
            r2_sector <= r1_sector;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: x = prod / 960 = (prod >> 6) / 15
    // ------------------------------------------------------------------
    logic [QMUL_W-1:0] w_qmul;
    logic [FW-1:0]     r3_x;
    logic [FW-1:0]     r3_chroma;
    logic [FW-1:0]     r3_ofs;
    logic [2:0]        r3_sector;

    assign w_qmul = QMUL_W'(r2_prod[PW-1:6]) * QMUL_W'(hsvrgb_pkg::RECIP15);

    always_ff @(posedge i_clk) begin
        if (w_rdy[2] && r_vld[1]) begin
            r3_x      <= w_qmul[hsvrgb_pkg::RECIP_SHIFT +: FW];
            r3_chroma <= r2_chroma;
            r3_ofs    <= r2_ofs;
            r3_sector <= r2_sector;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sector table and offset
    // ------------------------------------------------------------------
    logic [FW-1:0] w_cr;
    logic [FW-1:0] w_cg;
    logic [FW-1:0] w_cb;

    always_comb begin
        w_cr = '0;
        w_cg = '0;
        w_cb = '0;
        unique case (r3_sector)
            hsvrgb_pkg::SEC_RED_YEL: begin
                w_cr = r3_chroma;
                w_cg = r3_x;
            end
            hsvrgb_pkg::SEC_YEL_GRN: begin
                w_cr = r3_x;
                w_cg = r3_chroma;
            end
            hsvrgb_pkg::SEC_GRN_CYN: begin
                w_cg = r3_chroma;
                w_cb = r3_x;
            end
            hsvrgb_pkg::SEC_CYN_BLU: begin
                w_cg = r3_x;
                w_cb = r3_chroma;
            end
            hsvrgb_pkg::SEC_BLU_MAG: begin
                w_cr = r3_x;
                w_cb = r3_chroma;
            end
            default: begin
                w_cr = r3_chroma;
                w_cb = r3_x;
            end
        endcase
    end

    // component + offset never exceeds V*255 <= 65025
    logic [FW-1:0] r4_sum_r;
    logic [FW-1:0] r4_sum_g;
    logic [FW-1:0] r4_sum_b;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3] && r_vld[2]) begin
            r4_sum_r <= w_cr + r3_ofs;
            r4_sum_g <= w_cg + r3_ofs;
            r4_sum_b <= w_cb + r3_ofs;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: divide by 255, output register
    // ------------------------------------------------------------------
    logic [CW-1:0] w_red;
    logic [CW-1:0] w_grn;
    logic [CW-1:0] w_blu;

    hsvrgb_div255 u_div_r (.i_num(r4_sum_r), .o_quot(w_red));
    hsvrgb_div255 u_div_g (.i_num(r4_sum_g), .o_quot(w_grn));
    hsvrgb_div255 u_div_b (.i_num(r4_sum_b), .o_quot(w_blu));

    logic [hsvrgb_pkg::M_TDATA_W-1:0] r5_rgb;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4] && r_vld[3]) begin
            r5_rgb <= {w_blu, w_grn, w_red};
        end
    end

    assign o_m_tdata = r5_rgb;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // chroma plus offset is V*255, never above full scale
    a_ofs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (17'(r1_chroma) + 17'(r1_ofs)) <= 17'd65025)
        else $error("chroma + offset out of range");

    // ramp weight stays within one sector
    a_wgt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> r1_wgt <= WW'(hsvrgb_pkg::HUE_60))
        else $error("ramp weight above 960");

    // secondary component never exceeds chroma
    a_x_le_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> r3_x <= r3_chroma)
        else $error("x above chroma");

    // the middle stage keeps its item while stalled
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !w_rdy[2]) |=> r_vld[2])
        else $error("item lost in stalled stage");

    // input accepted into an empty pipe moves through every stage register to the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !r_vld[3] && !r_vld[4])
            |-> ##5 r_vld[4])
        else $error("item missing at output");

endmodule

FILE: hw/rtl/hsvrgb_div255.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_div255
// Truncating divide by 255 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module hsvrgb_div255 (
    input  logic [hsvrgb_pkg::FRAC_W-1:0] i_num,
    output logic [hsvrgb_pkg::CH_W-1:0]   o_quot
);

    localparam int MUL_W = hsvrgb_pkg::FRAC_W + hsvrgb_pkg::RECIP255_W;

    logic [MUL_W-1:0] w_prod;

    assign w_prod = MUL_W'(i_num) * MUL_W'(hsvrgb_pkg::RECIP255);
    // quotient never exceeds 255 for the legal input range
    assign o_quot = w_prod[hsvrgb_pkg::RECIP_SHIFT +: hsvrgb_pkg::CH_W];

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams HSV pixels through hsv_to_rgb_pixel and compares every RGB result,
// channel by channel, against an integer predictor. Directed corner pixels
// come first, then random pixels over four phases of idle and backpressure.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF     = 4;        // 8 ns period
    localparam int RESET_CYCLES = 7;
    localparam int RAND_PER_PHASE = 207;    // four phases, ~850 pixels in all
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    localparam int HUE_W     = hsvrgb_pkg::HUE_W;
    localparam int CH_W      = hsvrgb_pkg::CH_W;
    localparam int S_TDATA_W = hsvrgb_pkg::S_TDATA_W;
    localparam int M_TDATA_W = hsvrgb_pkg::M_TDATA_W;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    // ------------------------------------------------------------------------
    // Scoreboard: predicted pixels in acceptance order, checked in order.
    // ------------------------------------------------------------------------
    class rgb_scoreboard;
        t_rgb pending_pixels[$];
        int   mismatches = 0;

        static function automatic t_rgb hsv_to_rgb(logic [HUE_W-1:0] hue,
                                                   logic [CH_W-1:0] sat,
                                                   logic [CH_W-1:0] val);
            logic [15:0]      chroma;
            logic [15:0]      offset;
            logic [2:0]       sector;
            logic [HUE_W-1:0] phase;
            logic [31:0]      hue_dev;
            logic [31:0]      ramp;
            logic [15:0]      x;
            logic [15:0]      rc, gc, bc;
            t_rgb             px;
            chroma = 16'(val) * 16'(sat);
            offset = 16'(val) * 16'(hsvrgb_pkg::UNIT8) - chroma;
            // sector pinned at magenta-red for 300 degrees and beyond
            sector = (hue >= hsvrgb_pkg::HUE_300) ? hsvrgb_pkg::SEC_MAG_RED
                                                  : 3'(hue / hsvrgb_pkg::HUE_60);
            phase  = hue % hsvrgb_pkg::HUE_120;
            hue_dev = (phase >= hsvrgb_pkg::HUE_60) ? 32'(phase - hsvrgb_pkg::HUE_60)
                                                    : 32'(hsvrgb_pkg::HUE_60 - phase);
            ramp   = 32'(chroma) * (32'(hsvrgb_pkg::HUE_60) - hue_dev);
            x      = 16'(ramp / 32'(hsvrgb_pkg::HUE_60));
            rc = '0;
            gc = '0;
            bc = '0;
            case (sector)
                hsvrgb_pkg::SEC_RED_YEL: begin rc = chroma; gc = x; end
                hsvrgb_pkg::SEC_YEL_GRN: begin rc = x; gc = chroma; end
                hsvrgb_pkg::SEC_GRN_CYN: begin gc = chroma; bc = x; end
                hsvrgb_pkg::SEC_CYN_BLU: begin gc = x; bc = chroma; end
                hsvrgb_pkg::SEC_BLU_MAG: begin rc = x; bc = chroma; end
                default: begin rc = chroma; bc = x; end
            endcase
            px.red   = 8'((32'(rc) + 32'(offset)) / 32'(hsvrgb_pkg::UNIT8));
            px.green = 8'((32'(gc) + 32'(offset)) / 32'(hsvrgb_pkg::UNIT8));
            px.blue  = 8'((32'(bc) + 32'(offset)) / 32'(hsvrgb_pkg::UNIT8));
            return px;
        endfunction

        task report(string msg);
            $display("tb: mismatch: %s", msg);
            mismatches++;
        endtask

        function void note_pixel(logic [S_TDATA_W-1:0] tdata);
            pending_pixels.push_back(hsv_to_rgb(tdata[12:0], tdata[20:13], tdata[28:21]));
        endfunction

        task check_pixel(logic [M_TDATA_W-1:0] tdata);
            t_rgb want;
            if (pending_pixels.size() == 0) begin
                report($sformatf("unexpected pixel %06h", tdata));
            end else begin
                want = pending_pixels.pop_front();
                if (tdata[7:0] != want.red)
                    report($sformatf("red %0d, want %0d", tdata[7:0], want.red));
                if (tdata[15:8] != want.green)
                    report($sformatf("green %0d, want %0d", tdata[15:8], want.green));
                if (tdata[23:16] != want.blue)
                    report($sformatf("blue %0d, want %0d", tdata[23:16], want.blue));
            end
        endtask

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // hue[12:0], saturation[20:13], brightness[28:21], zero pad [31:29]
    logic [S_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // red[7:0], green[15:8], blue[23:16]
    logic [M_TDATA_W-1:0]  o_m_tdata;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int cycle_count     = 0;

    rgb_scoreboard sb = new;

    hsv_to_rgb_pixel i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Watchdog: a hung pipeline ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver backpressure, rerolled every cycle; one NBA per edge.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: sampled at the edge, so both sides see pre-edge values.
    // Input side first, so a zero-latency result would still find its entry.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.note_pixel(i_s_tdata);
            if (o_m_tvalid && i_m_tready)
                sb.check_pixel(o_m_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // One input transaction. Idle cycles are rolled per cycle so the gap
    // length is geometric; valid stays high back to back when no idle hits.
    task send_pixel(logic [HUE_W-1:0] hue, logic [CH_W-1:0] sat, logic [CH_W-1:0] val);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, val, sat, hue};
        do
            @(posedge i_clk);
        while (!o_s_tready);
    endtask

    // Mostly the legal circle, some hue past 360 degrees, some sector edges.
    function automatic logic [HUE_W-1:0] rand_hue();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75)
            return HUE_W'($urandom_range(5760));
        else if (pick < 87)
            return HUE_W'($urandom_range(8191, 5761));
        else
            return HUE_W'(int'($urandom_range(6)) * 960 - 1 + int'($urandom_range(2)));
    endfunction

    // Extremes often, since zero and full scale are the degenerate cases.
    function automatic logic [CH_W-1:0] rand_chan();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        else if (pick < 20)
            return '1;
        else
            return CH_W'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: sector boundaries at full S and V, hue wrap at 360,
        // hue past 360 (sector stays magenta-red), zero S, zero V, tiny values.
        send_pixel(13'd0,    8'd255, 8'd255);
        send_pixel(13'd959,  8'd255, 8'd255);
        send_pixel(13'd960,  8'd255, 8'd255);
        send_pixel(13'd1919, 8'd255, 8'd255);
        send_pixel(13'd1920, 8'd255, 8'd255);
        send_pixel(13'd2879, 8'd255, 8'd255);
        send_pixel(13'd2880, 8'd255, 8'd255);
        send_pixel(13'd3840, 8'd255, 8'd255);
        send_pixel(13'd4800, 8'd255, 8'd255);
        send_pixel(13'd5759, 8'd255, 8'd255);
        send_pixel(13'd5760, 8'd255, 8'd255);
        send_pixel(13'd5761, 8'd255, 8'd255);
        send_pixel(13'd7680, 8'd255, 8'd255);
        send_pixel(13'd8191, 8'd255, 8'd255);
        send_pixel(13'd480,  8'd0,   8'd200);
        send_pixel(13'd3000, 8'd0,   8'd255);
        send_pixel(13'd1500, 8'd255, 8'd0);
        send_pixel(13'd0,    8'd0,   8'd0);
        send_pixel(13'd2400, 8'd1,   8'd1);
        send_pixel(13'd4321, 8'd128, 8'd77);
        send_pixel(13'd8191, 8'd0,   8'd255);
        send_pixel(13'd6000, 8'd200, 8'd100);

        // Random: no idling, sender idle, receiver stall, both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin sender_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++)
                send_pixel(rand_hue(), rand_chan(), rand_chan());
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
